// ===== design/plm_pkg.sv =====
// Shared types and codes for the positional list engine.
package plm_pkg;

  // Fixed field widths of the request and result ports.
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // Request kinds. The unused code is handled as a read.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== design/plm_cell.sv =====
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
module plm_cell import plm_pkg::*; #(
  parameter int PW    = 6,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [PW-1:0]     pos,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] sel_data
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [DATA_W-1:0] data_next;

  // Insert writes the new value here or takes the lower neighbor's entry;
  // remove takes the upper neighbor's entry from the addressed slot on.
  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (IDX == pos) begin
        data_next = cmd.value;
      end else if (IDX > pos) begin
        data_next = left_data;
      end
    end else if (cmd.rem) begin
      if (IDX >= pos) begin
        data_next = right_data;
      end
    end
  end

  // The entry itself needs no reset; unwritten slots are never observed.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the addressed cell drives its entry onto the read bus.
  assign sel_data = (IDX == pos) ? data : '0;

endmodule

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: request register, cell chain and result register.
// Timing: a request is captured in the request register, and its result, with done high,
//   is then registered in the result register.
// Throughput: one request per cycle; busy stays low, since every cell shifts in parallel.
// The count seen by a request includes every earlier request, so back-to-back
//   requests act in order.
// Reset (rst, synchronous) empties the list and drops any request in flight.
module positional_list_engine import plm_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] value_out,
  output logic [COUNT_W-1:0]       count,
  output logic                     empty_res
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW-1:0] FULL_CNT = PW'(DEPTH);

  // Request register.
  logic                req_valid;
  logic [KIND_W-1:0]   req_kind;
  logic [POS_W-1:0]    req_pos;
  logic [DATA_W-1:0]   req_val;

  // List size.
  logic [CW-1:0]       entry_count;
  logic [CW-1:0]       entry_count_next;

  // Chain signals.
  cell_cmd_t           cmd;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic [DATA_W-1:0]   cell_data [DEPTH];
  logic [DATA_W-1:0]   cell_sel  [DEPTH];
  logic [DATA_W-1:0]   rd_data;

  // Result decode.
  logic [STAT_W-1:0]   status_next;
  logic [DATA_W-1:0]   value_next;
  logic                is_insert;
  logic                is_remove;
  logic                pos_lt_cnt;
  logic                pos_le_cnt;
  logic                is_full;

  // The chain takes a request every cycle.
  assign busy = 1'b0;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind <= kind;
      req_pos  <= position;
      req_val  <= value_in;
    end
  end

  // Range and capacity checks against the current size.
  always_comb begin
    pos_ext    = PW'(req_pos);
    cnt_ext    = PW'(entry_count);
    pos_lt_cnt = pos_ext < cnt_ext;
    pos_le_cnt = pos_ext <= cnt_ext;
    is_full    = cnt_ext == FULL_CNT;
    is_insert  = 1'b0;
    is_remove  = 1'b0;
    case (req_kind)
      KIND_INSERT: is_insert = 1'b1;
      KIND_REMOVE: is_remove = 1'b1;
      default:     ;
    endcase
  end

  // Shift command for the chain.
  always_comb begin
    cmd.ins   = req_valid && is_insert && pos_le_cnt && !is_full;
    cmd.rem   = req_valid && is_remove && pos_lt_cnt;
    cmd.value = req_val;
  end

  // Row of cells; each neighbor pair is wired both ways.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plm_cell #(
      .PW    (PW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_ext),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .sel_data   (cell_sel[i])
    );
  end

  // Read bus: at most one cell drives a nonzero word.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_sel[i];
    end
  end

  // Status, returned value and new size.
  always_comb begin
    status_next      = ST_DONE;
    value_next       = '0;
    entry_count_next = entry_count;
    if (is_insert) begin
      if (!pos_le_cnt) begin
        status_next = ST_RANGE;
      end else if (is_full) begin
        status_next = ST_FULL;
      end else begin
        entry_count_next = entry_count + 1'b1;
      end
    end else if (!pos_lt_cnt) begin
      status_next = ST_RANGE;
    end else begin
      value_next = rd_data;
      if (is_remove) begin
        entry_count_next = entry_count - 1'b1;
      end
    end
  end

  // Size register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        entry_count <= entry_count_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      status    <= status_next;
      value_out <= value_next;
      count     <= COUNT_W'(PW'(entry_count_next));
      empty_res <= entry_count_next == '0;
    end
  end

endmodule

// ===== design/plm_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
module plm_checker import plm_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [STAT_W-1:0]        status,
  input logic signed [DATA_W-1:0] value_out,
  input logic [COUNT_W-1:0]       count,
  input logic                     empty_res
);

  // Every accepted request yields its result.
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  // A result never appears without an earlier accepted request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a request");

  // Failed requests return no data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> value_out == '0)
    else $error("error result carries data");

  // An empty list reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && empty_res) |-> count == '0)
    else $error("empty flag with nonzero count");

endmodule

bind positional_list_engine plm_checker u_plm_checker (.*);
